// ----- sv/sgv_pkg.sv -----
`default_nettype none
package sgv_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COORD_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
   localparam int BANK_AW = COL_W + ROW_W - 2;
   localparam int BANK_DEPTH = (MAX_COLS * MAX_ROWS) / 4;
   localparam int NUM_BANKS = 4;

   localparam int CNT_W = 7;
   localparam int DOM_W = 16;
   localparam int VEL_W = 32;
   localparam int POS_W = 32;
   localparam int FRAC_W = 16;
   localparam int NUM_W = POS_W + CNT_W;
   localparam int QUO_W = 24;
   localparam int DIV_STEPS = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;
   localparam int PROD_W = VEL_W + FRAC_W + 2;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] OP_WRITE_H = 2'd0;
   localparam logic [1:0] OP_WRITE_V = 2'd1;
   localparam logic [1:0] OP_SAMPLE  = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN_HEIGHT = 2'd3;

   typedef struct packed {
      logic [1:0]              operation;
      logic [5:0]              cell_col;
      logic [5:0]              cell_row;
      logic signed [VEL_W-1:0] entry_velocity;
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
   } sgv_req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
   } sgv_rsp_type;

   typedef struct packed {
      logic [1:0]              operation;
      logic [5:0]              cell_col;
      logic [5:0]              cell_row;
      logic signed [VEL_W-1:0] entry_velocity;
   } sgv_wr_type;

   typedef struct packed {
      logic             ovf;
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } sgv_div_type;

   typedef struct packed {
      logic               hit;
      logic [BANK_AW-1:0] addr;
   } sgv_bank_type;

endpackage
`default_nettype wire

// ----- sv/sgv_ram.sv -----
`default_nettype none
module sgv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- sv/staggered_grid_velocity_sample.sv -----
// Staggered-grid velocity sampler. Requests of operation write-horizontal or write-vertical
// load one face velocity into the chosen grid; sample requests return the bilinearly
// interpolated velocity at a Q16.16 point, one response each, and writes return nothing.
// Software must load every grid entry a sample can reach before sampling; the grids are not
// cleared at reset. The user must see that configuration is written only while no request
// is in flight; the block does not enforce it. One request is taken every clock cycle
// while no response is stalled; each grid is split into four banks by column and row
// parity so the four neighbours of a sample are read in the same cycle. The position to
// cell mapping uses a pipelined restoring divider of three quotient bits per stage.
// Writes and reads hit the grids at the same pipeline stage, so every sample sees all
// earlier writes. A stalled response holds the whole pipeline.
`default_nettype none
module staggered_grid_velocity_sample (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sgv_pkg::sgv_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sgv_pkg::sgv_rsp_type                rsp_data,
   input  logic                                csr_wr_en,
   input  logic [sgv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgv_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DS = sgv_pkg::DIV_STAGES;
   localparam int CW = sgv_pkg::COORD_W;

   function automatic sgv_pkg::sgv_div_type div_steps(
      input sgv_pkg::sgv_div_type        cur,
      input logic [sgv_pkg::DOM_W-1:0]  dom,
      input int                          st
   );
      sgv_pkg::sgv_div_type       nxt;
      logic [sgv_pkg::NUM_W:0]    sub;
      int                         k;
      int                         s;
      nxt = cur;
      if (st == 0) begin
         nxt.ovf = {1'b0, cur.rem} >= ((sgv_pkg::NUM_W+1)'(dom) << sgv_pkg::QUO_W);
      end
      for (s = 0; s < sgv_pkg::DIV_STEPS; s++) begin
         k = sgv_pkg::QUO_W - 1 - st * sgv_pkg::DIV_STEPS - s;
         sub = (sgv_pkg::NUM_W+1)'(dom) << k;
         if ({1'b0, nxt.rem} >= sub) begin
            nxt.rem = nxt.rem - sub[sgv_pkg::NUM_W-1:0];
            nxt.quo = {nxt.quo[sgv_pkg::QUO_W-2:0], 1'b1};
         end else begin
            nxt.quo = {nxt.quo[sgv_pkg::QUO_W-2:0], 1'b0};
         end
      end
      return nxt;
   endfunction

   function automatic sgv_pkg::sgv_bank_type bank_pick(
      input logic signed [CW-1:0]       c0,
      input logic signed [CW-1:0]       r0,
      input logic                       cp,
      input logic                       rp,
      input logic [sgv_pkg::CNT_W-1:0]  ncols,
      input logic [sgv_pkg::CNT_W-1:0]  nrows
   );
      sgv_pkg::sgv_bank_type   res;
      logic signed [CW-1:0]    c;
      logic signed [CW-1:0]    r;
      c = (c0[0] == cp) ? c0 : c0 + CW'(1);
      r = (r0[0] == rp) ? r0 : r0 + CW'(1);
      res.hit = !c[CW-1] && !r[CW-1] && (c < signed'(CW'(ncols)))
                && (r < signed'(CW'(nrows)));
      res.addr = {r[sgv_pkg::ROW_W-1:1], c[sgv_pkg::COL_W-1:1]};
      return res;
   endfunction

   function automatic logic signed [sgv_pkg::PROD_W-1:0] mulw(
      input logic signed [sgv_pkg::VEL_W-1:0] a,
      input logic [sgv_pkg::FRAC_W:0]         w
   );
      logic signed [sgv_pkg::PROD_W-1:0] ae;
      logic signed [sgv_pkg::PROD_W-1:0] we;
      ae = sgv_pkg::PROD_W'(a);
      we = signed'(sgv_pkg::PROD_W'(w));
      return ae * we;
   endfunction

   function automatic logic [sgv_pkg::FRAC_W:0] wcomp(input logic [sgv_pkg::FRAC_W-1:0] w);
      return (sgv_pkg::FRAC_W+1)'(1 << sgv_pkg::FRAC_W) - (sgv_pkg::FRAC_W+1)'(w);
   endfunction

   function automatic logic signed [sgv_pkg::VEL_W-1:0] lerp_end(
      input logic signed [sgv_pkg::PROD_W-1:0] p0,
      input logic signed [sgv_pkg::PROD_W-1:0] p1
   );
      logic signed [sgv_pkg::PROD_W:0] s;
      logic signed [sgv_pkg::PROD_W:0] r;
      s = (sgv_pkg::PROD_W+1)'(p0) + (sgv_pkg::PROD_W+1)'(p1)
          + (sgv_pkg::PROD_W+1)'(1 << (sgv_pkg::FRAC_W - 1));
      r = s >>> sgv_pkg::FRAC_W;
      if (r > (sgv_pkg::PROD_W+1)'(2147483647)) begin
         return sgv_pkg::VEL_W'(2147483647);
      end else if (r < -(sgv_pkg::PROD_W+1)'(64'sd2147483648)) begin
         return {1'b1, {(sgv_pkg::VEL_W-1){1'b0}}};
      end
      return r[sgv_pkg::VEL_W-1:0];
   endfunction

   // configuration
   logic [sgv_pkg::CNT_W-1:0] cols_ff, rows_ff;
   logic [sgv_pkg::DOM_W-1:0] dom_w_ff, dom_h_ff;
   logic [sgv_pkg::CNT_W-1:0] cols_eff, rows_eff;
   logic                      dom_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= sgv_pkg::CNT_W'(64);
         rows_ff  <= sgv_pkg::CNT_W'(64);
         dom_w_ff <= sgv_pkg::DOM_W'(64);
         dom_h_ff <= sgv_pkg::DOM_W'(64);
      end else if (csr_wr_en) begin
         case (csr_index)
            sgv_pkg::REG_GRID_COLS:     cols_ff  <= csr_wdata[sgv_pkg::CNT_W-1:0];
            sgv_pkg::REG_GRID_ROWS:     rows_ff  <= csr_wdata[sgv_pkg::CNT_W-1:0];
            sgv_pkg::REG_DOMAIN_WIDTH:  dom_w_ff <= csr_wdata;
            sgv_pkg::REG_DOMAIN_HEIGHT: dom_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = sgv_pkg::CNT_W'(1);
      end else if (cols_ff > sgv_pkg::CNT_W'(sgv_pkg::MAX_COLS)) begin
         cols_eff = sgv_pkg::CNT_W'(sgv_pkg::MAX_COLS);
      end else begin
         cols_eff = cols_ff;
      end
      if (rows_ff == '0) begin
         rows_eff = sgv_pkg::CNT_W'(1);
      end else if (rows_ff > sgv_pkg::CNT_W'(sgv_pkg::MAX_ROWS)) begin
         rows_eff = sgv_pkg::CNT_W'(sgv_pkg::MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
      dom_zero = (dom_w_ff == '0) || (dom_h_ff == '0);
   end

   // pipeline control
   logic adv;
   logic rsp_valid_ff;
   sgv_pkg::sgv_rsp_type rsp_data_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // input stage
   logic                 in_v_ff;
   sgv_pkg::sgv_req_type in_ff;

   // numerator stage and divider
   logic [DS:0]          dv_ff;
   sgv_pkg::sgv_wr_type  dw_ff [DS+1];
   sgv_pkg::sgv_div_type dx_ff [DS+1];
   sgv_pkg::sgv_div_type dy_ff [DS+1];
   sgv_pkg::sgv_div_type dx_in [DS+1];
   sgv_pkg::sgv_div_type dy_in [DS+1];

   always_comb begin
      dx_in[0].ovf = 1'b0;
      dx_in[0].rem = sgv_pkg::NUM_W'(in_ff.pos_x) * sgv_pkg::NUM_W'(cols_eff);
      dx_in[0].quo = '0;
      dy_in[0].ovf = 1'b0;
      dy_in[0].rem = sgv_pkg::NUM_W'(in_ff.pos_y) * sgv_pkg::NUM_W'(rows_eff);
      dy_in[0].quo = '0;
      for (int st = 0; st < DS; st++) begin
         dx_in[st+1] = div_steps(dx_ff[st], dom_w_ff, st);
         dy_in[st+1] = div_steps(dy_ff[st], dom_h_ff, st);
      end
   end

   // cell, fraction and neighbour origin
   logic                         e_v_ff;
   sgv_pkg::sgv_wr_type          e_wr_ff;
   logic                         e_out_ff, e_out_in;
   logic [sgv_pkg::FRAC_W-1:0]   e_fx_ff, e_fy_ff;
   logic signed [CW-1:0]         e_hc_ff, e_hr_ff, e_vc_ff, e_vr_ff;
   logic signed [CW-1:0]         e_hr_in, e_vc_in, e_i, e_j;
   logic [sgv_pkg::QUO_W-1:0]    qx, qy;

   always_comb begin
      qx = dx_ff[DS].quo;
      qy = dy_ff[DS].quo;
      e_out_in = dx_ff[DS].ovf || dy_ff[DS].ovf || dom_zero
                 || (qx[sgv_pkg::QUO_W-1:sgv_pkg::FRAC_W]
                     >= (sgv_pkg::QUO_W-sgv_pkg::FRAC_W)'(cols_eff))
                 || (qy[sgv_pkg::QUO_W-1:sgv_pkg::FRAC_W]
                     >= (sgv_pkg::QUO_W-sgv_pkg::FRAC_W)'(rows_eff));
      e_i = signed'(CW'(qx[sgv_pkg::FRAC_W +: sgv_pkg::COL_W]));
      e_j = signed'(CW'(qy[sgv_pkg::FRAC_W +: sgv_pkg::ROW_W]));
      e_hr_in = qy[sgv_pkg::FRAC_W-1] ? e_j : e_j - CW'(1);
      e_vc_in = qx[sgv_pkg::FRAC_W-1] ? e_i : e_i - CW'(1);
   end

   // bank selection, grid access
   sgv_pkg::sgv_bank_type      h_pick [sgv_pkg::NUM_BANKS];
   sgv_pkg::sgv_bank_type      v_pick [sgv_pkg::NUM_BANKS];
   logic [sgv_pkg::NUM_BANKS-1:0] h_we, v_we;
   logic [sgv_pkg::BANK_AW-1:0]   w_addr;
   logic [1:0]                    w_bank;
   logic [sgv_pkg::VEL_W-1:0]     h_rd [sgv_pkg::NUM_BANKS];
   logic [sgv_pkg::VEL_W-1:0]     v_rd [sgv_pkg::NUM_BANKS];

   always_comb begin
      w_bank = {e_wr_ff.cell_row[0], e_wr_ff.cell_col[0]};
      w_addr = {e_wr_ff.cell_row[sgv_pkg::ROW_W-1:1], e_wr_ff.cell_col[sgv_pkg::COL_W-1:1]};
      for (int b = 0; b < sgv_pkg::NUM_BANKS; b++) begin
         h_pick[b] = bank_pick(e_hc_ff, e_hr_ff, 1'(b), 1'(b >> 1), cols_eff, rows_eff);
         v_pick[b] = bank_pick(e_vc_ff, e_vr_ff, 1'(b), 1'(b >> 1), cols_eff, rows_eff);
         h_we[b] = adv && e_v_ff && (e_wr_ff.operation == sgv_pkg::OP_WRITE_H)
                   && (w_bank == 2'(b));
         v_we[b] = adv && e_v_ff && (e_wr_ff.operation == sgv_pkg::OP_WRITE_V)
                   && (w_bank == 2'(b));
      end
   end

   for (genvar g = 0; g < sgv_pkg::NUM_BANKS; g++) begin : g_bank
      sgv_ram #(.WIDTH(sgv_pkg::VEL_W), .DEPTH(sgv_pkg::BANK_DEPTH)) u_hram (
         .clock   (clock),
         .wr_en   (h_we[g]),
         .wr_addr (w_addr),
         .wr_data (e_wr_ff.entry_velocity),
         .rd_en   (adv),
         .rd_addr (h_pick[g].addr),
         .rd_data (h_rd[g])
      );
      sgv_ram #(.WIDTH(sgv_pkg::VEL_W), .DEPTH(sgv_pkg::BANK_DEPTH)) u_vram (
         .clock   (clock),
         .wr_en   (v_we[g]),
         .wr_addr (w_addr),
         .wr_data (e_wr_ff.entry_velocity),
         .rd_en   (adv),
         .rd_addr (v_pick[g].addr),
         .rd_data (v_rd[g])
      );
   end

   // neighbour select and first products
   logic                          a_v_ff;
   logic [1:0]                    a_op_ff;
   logic                          a_out_ff;
   logic [sgv_pkg::FRAC_W-1:0]    a_fx_ff, a_fy_ff;
   logic [sgv_pkg::NUM_BANKS-1:0] a_hhit_ff, a_vhit_ff;
   logic                          a_hcp_ff, a_hrp_ff, a_vcp_ff, a_vrp_ff;
   logic [1:0]                    hb_a, hb_b, hb_c, hb_d, vb_a, vb_b, vb_c, vb_d;
   logic signed [sgv_pkg::VEL_W-1:0] ha, hb, hc, hd, va, vb, vc, vd;
   logic signed [sgv_pkg::PROD_W-1:0] l1_p_in [8];

   always_comb begin
      hb_a = {a_hrp_ff, a_hcp_ff};
      hb_b = {a_hrp_ff, ~a_hcp_ff};
      hb_c = {~a_hrp_ff, a_hcp_ff};
      hb_d = {~a_hrp_ff, ~a_hcp_ff};
      vb_a = {a_vrp_ff, a_vcp_ff};
      vb_b = {a_vrp_ff, ~a_vcp_ff};
      vb_c = {~a_vrp_ff, a_vcp_ff};
      vb_d = {~a_vrp_ff, ~a_vcp_ff};
      ha = a_hhit_ff[hb_a] ? signed'(h_rd[hb_a]) : '0;
      hb = a_hhit_ff[hb_b] ? signed'(h_rd[hb_b]) : '0;
      hc = a_hhit_ff[hb_c] ? signed'(h_rd[hb_c]) : '0;
      hd = a_hhit_ff[hb_d] ? signed'(h_rd[hb_d]) : '0;
      va = a_vhit_ff[vb_a] ? signed'(v_rd[vb_a]) : '0;
      vb = a_vhit_ff[vb_b] ? signed'(v_rd[vb_b]) : '0;
      vc = a_vhit_ff[vb_c] ? signed'(v_rd[vb_c]) : '0;
      vd = a_vhit_ff[vb_d] ? signed'(v_rd[vb_d]) : '0;
      l1_p_in[0] = mulw(ha, wcomp(a_fx_ff));
      l1_p_in[1] = mulw(hb, (sgv_pkg::FRAC_W+1)'(a_fx_ff));
      l1_p_in[2] = mulw(hc, wcomp(a_fx_ff));
      l1_p_in[3] = mulw(hd, (sgv_pkg::FRAC_W+1)'(a_fx_ff));
      l1_p_in[4] = mulw(va, wcomp(a_fy_ff));
      l1_p_in[5] = mulw(vc, (sgv_pkg::FRAC_W+1)'(a_fy_ff));
      l1_p_in[6] = mulw(vb, wcomp(a_fy_ff));
      l1_p_in[7] = mulw(vd, (sgv_pkg::FRAC_W+1)'(a_fy_ff));
   end

   logic                              l1_v_ff;
   logic [1:0]                        l1_op_ff;
   logic                              l1_out_ff;
   logic [sgv_pkg::FRAC_W-1:0]        l1_wx_ff, l1_wy_ff;
   logic signed [sgv_pkg::PROD_W-1:0] l1_p_ff [8];

   logic                              l2_v_ff;
   logic [1:0]                        l2_op_ff;
   logic                              l2_out_ff;
   logic [sgv_pkg::FRAC_W-1:0]        l2_wx_ff, l2_wy_ff;
   logic signed [sgv_pkg::VEL_W-1:0]  l2_h1_ff, l2_h2_ff, l2_v1_ff, l2_v2_ff;

   logic                              l3_v_ff;
   logic [1:0]                        l3_op_ff;
   logic                              l3_out_ff;
   logic signed [sgv_pkg::PROD_W-1:0] l3_p_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff      <= 1'b0;
         dv_ff        <= '0;
         e_v_ff       <= 1'b0;
         a_v_ff       <= 1'b0;
         l1_v_ff      <= 1'b0;
         l2_v_ff      <= 1'b0;
         l3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         in_v_ff      <= req_valid;
         dv_ff        <= {dv_ff[DS-1:0], in_v_ff};
         e_v_ff       <= dv_ff[DS];
         a_v_ff       <= e_v_ff;
         l1_v_ff      <= a_v_ff;
         l2_v_ff      <= l1_v_ff;
         l3_v_ff      <= l2_v_ff;
         rsp_valid_ff <= l3_v_ff && (l3_op_ff == sgv_pkg::OP_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;

         dw_ff[0].operation      <= in_ff.operation;
         dw_ff[0].cell_col       <= in_ff.cell_col;
         dw_ff[0].cell_row       <= in_ff.cell_row;
         dw_ff[0].entry_velocity <= in_ff.entry_velocity;
         dx_ff[0] <= dx_in[0];
         dy_ff[0] <= dy_in[0];
         for (int st = 0; st < DS; st++) begin
            dw_ff[st+1] <= dw_ff[st];
            dx_ff[st+1] <= dx_in[st+1];
            dy_ff[st+1] <= dy_in[st+1];
         end

         e_wr_ff  <= dw_ff[DS];
         e_out_ff <= e_out_in;
         e_fx_ff  <= qx[sgv_pkg::FRAC_W-1:0];
         e_fy_ff  <= qy[sgv_pkg::FRAC_W-1:0];
         e_hc_ff  <= e_i;
         e_hr_ff  <= e_hr_in;
         e_vc_ff  <= e_vc_in;
         e_vr_ff  <= e_j;

         a_op_ff  <= e_wr_ff.operation;
         a_out_ff <= e_out_ff;
         a_fx_ff  <= e_fx_ff;
         a_fy_ff  <= e_fy_ff;
         a_hcp_ff <= e_hc_ff[0];
         a_hrp_ff <= e_hr_ff[0];
         a_vcp_ff <= e_vc_ff[0];
         a_vrp_ff <= e_vr_ff[0];
         for (int b = 0; b < sgv_pkg::NUM_BANKS; b++) begin
            a_hhit_ff[b] <= h_pick[b].hit;
            a_vhit_ff[b] <= v_pick[b].hit;
         end

         l1_op_ff  <= a_op_ff;
         l1_out_ff <= a_out_ff;
         // half-cell offset on the staggered axis
         l1_wx_ff  <= {~a_fx_ff[sgv_pkg::FRAC_W-1], a_fx_ff[sgv_pkg::FRAC_W-2:0]};
         l1_wy_ff  <= {~a_fy_ff[sgv_pkg::FRAC_W-1], a_fy_ff[sgv_pkg::FRAC_W-2:0]};
         for (int p = 0; p < 8; p++) begin
            l1_p_ff[p] <= l1_p_in[p];
         end

         l2_op_ff  <= l1_op_ff;
         l2_out_ff <= l1_out_ff;
         l2_wx_ff  <= l1_wx_ff;
         l2_wy_ff  <= l1_wy_ff;
         l2_h1_ff  <= lerp_end(l1_p_ff[0], l1_p_ff[1]);
         l2_h2_ff  <= lerp_end(l1_p_ff[2], l1_p_ff[3]);
         l2_v1_ff  <= lerp_end(l1_p_ff[4], l1_p_ff[5]);
         l2_v2_ff  <= lerp_end(l1_p_ff[6], l1_p_ff[7]);

         l3_op_ff   <= l2_op_ff;
         l3_out_ff  <= l2_out_ff;
         l3_p_ff[0] <= mulw(l2_h1_ff, wcomp(l2_wy_ff));
         l3_p_ff[1] <= mulw(l2_h2_ff, (sgv_pkg::FRAC_W+1)'(l2_wy_ff));
         l3_p_ff[2] <= mulw(l2_v1_ff, wcomp(l2_wx_ff));
         l3_p_ff[3] <= mulw(l2_v2_ff, (sgv_pkg::FRAC_W+1)'(l2_wx_ff));

         rsp_data_ff.vel_x <= l3_out_ff ? '0 : lerp_end(l3_p_ff[0], l3_p_ff[1]);
         rsp_data_ff.vel_y <= l3_out_ff ? '0 : lerp_end(l3_p_ff[2], l3_p_ff[3]);
      end
   end

   a_h_write_owner: assert property (@(posedge clock) disable iff (reset)
      (|h_we) |-> (e_v_ff && (e_wr_ff.operation == sgv_pkg::OP_WRITE_H) && $onehot(h_we)))
      else $error("horizontal grid write without a matching write request");

   a_v_write_owner: assert property (@(posedge clock) disable iff (reset)
      (|v_we) |-> (e_v_ff && (e_wr_ff.operation == sgv_pkg::OP_WRITE_V) && $onehot(v_we)))
      else $error("vertical grid write without a matching write request");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no blocked response");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (adv && l3_v_ff && (l3_op_ff != sgv_pkg::OP_SAMPLE)) |=> !rsp_valid)
      else $error("response produced for a non-sample request");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 24;
   localparam int LOAD_SIDE = 8;
   localparam int PHASE_ITEMS = 168;

   class velocity_scoreboard;
      logic signed [31:0] horiz_face [4096];
      logic signed [31:0] vert_face [4096];
      logic [6:0] n_cols;
      logic [6:0] n_rows;
      logic [15:0] dom_w;
      logic [15:0] dom_h;
      sgv_pkg::sgv_rsp_type expected_vel [$];
      int errors;

      function new();
         n_cols = 7'd64;
         n_rows = 7'd64;
         dom_w = 16'd64;
         dom_h = 16'd64;
         errors = 0;
      endfunction

      function void set_reg(logic [sgv_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            sgv_pkg::REG_GRID_COLS: n_cols = val[6:0];
            sgv_pkg::REG_GRID_ROWS: n_rows = val[6:0];
            sgv_pkg::REG_DOMAIN_WIDTH: dom_w = val;
            sgv_pkg::REG_DOMAIN_HEIGHT: dom_h = val;
            default: ;
         endcase
      endfunction

      function longint face(bit horiz, longint c, longint r, longint nc, longint nr);
         if (c < 0 || c >= nc || r < 0 || r >= nr) return 0;
         return horiz ? longint'(horiz_face[r * 64 + c]) : longint'(vert_face[r * 64 + c]);
      endfunction

      function longint blend(longint a, longint b, longint w);
         longint s;
         s = a * (65536 - w) + b * w;
         s = (s + 32768) >>> 16;
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         return s;
      endfunction

      function sgv_pkg::sgv_rsp_type interpolate(logic [31:0] px, logic [31:0] py);
         sgv_pkg::sgv_rsp_type v;
         longint nc, nr, i, j, fx, fy, wx, wy, tr, lc, hv, vv;
         logic [63:0] ux, uy;
         bit left, top;
         v = '0;
         nc = (n_cols == 0) ? 1 : ((n_cols > sgv_pkg::MAX_COLS) ? sgv_pkg::MAX_COLS : n_cols);
         nr = (n_rows == 0) ? 1 : ((n_rows > sgv_pkg::MAX_ROWS) ? sgv_pkg::MAX_ROWS : n_rows);
         if (dom_w == 0 || dom_h == 0) return v;
         ux = ({32'b0, px} * 64'(nc)) / 64'(dom_w);
         uy = ({32'b0, py} * 64'(nr)) / 64'(dom_h);
         if ((ux >> 16) >= 64'(nc) || (uy >> 16) >= 64'(nr)) return v;
         i = longint'(ux >> 16);
         j = longint'(uy >> 16);
         fx = longint'(ux[15:0]);
         fy = longint'(uy[15:0]);
         left = fx < 32768;
         top = fy < 32768;
         tr = top ? j - 1 : j;
         wy = top ? fy + 32768 : fy - 32768;
         hv = blend(blend(face(1, i, tr, nc, nr), face(1, i + 1, tr, nc, nr), fx),
                    blend(face(1, i, tr + 1, nc, nr), face(1, i + 1, tr + 1, nc, nr), fx), wy);
         lc = left ? i - 1 : i;
         wx = left ? fx + 32768 : fx - 32768;
         vv = blend(blend(face(0, lc, j, nc, nr), face(0, lc, j + 1, nc, nr), fy),
                    blend(face(0, lc + 1, j, nc, nr), face(0, lc + 1, j + 1, nc, nr), fy), wx);
         v.vel_x = hv[31:0];
         v.vel_y = vv[31:0];
         return v;
      endfunction

      function void note(sgv_pkg::sgv_req_type r);
         case (r.operation)
            sgv_pkg::OP_WRITE_H: horiz_face[{r.cell_row, r.cell_col}] = r.entry_velocity;
            sgv_pkg::OP_WRITE_V: vert_face[{r.cell_row, r.cell_col}] = r.entry_velocity;
            sgv_pkg::OP_SAMPLE: expected_vel.push_back(interpolate(r.pos_x, r.pos_y));
            default: ;
         endcase
      endfunction

      function void check(sgv_pkg::sgv_rsp_type got);
         sgv_pkg::sgv_rsp_type want;
         if (expected_vel.size() == 0) begin
            $error("unexpected response vel_x=%h vel_y=%h", got.vel_x, got.vel_y);
            errors++;
            return;
         end
         want = expected_vel.pop_front();
         if (got.vel_x !== want.vel_x) begin
            $error("vel_x expected %h actual %h", want.vel_x, got.vel_x);
            errors++;
         end
         if (got.vel_y !== want.vel_y) begin
            $error("vel_y expected %h actual %h", want.vel_y, got.vel_y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   sgv_pkg::sgv_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   sgv_pkg::sgv_rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [sgv_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sgv_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   velocity_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int quiet_cycles = 0;

   staggered_grid_velocity_sample u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note(req_data);
         if (rsp_valid && !rsp_stall) sb.check(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task send(input sgv_pkg::sgv_req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task drain();
      req_valid <= 0;
      @(negedge clock);
      while (sb.expected_vel.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task write_reg(input logic [sgv_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task configure(input logic [15:0] c, input logic [15:0] r, input logic [15:0] w,
                  input logic [15:0] h);
      write_reg(sgv_pkg::REG_GRID_COLS, c);
      write_reg(sgv_pkg::REG_GRID_ROWS, r);
      write_reg(sgv_pkg::REG_DOMAIN_WIDTH, w);
      write_reg(sgv_pkg::REG_DOMAIN_HEIGHT, h);
      csr_wr_en <= 0;
   endtask

   function sgv_pkg::sgv_req_type make_write(logic [1:0] op, logic [5:0] c, logic [5:0] r,
                                             logic [31:0] v);
      sgv_pkg::sgv_req_type q;
      q = '0;
      q.operation = op;
      q.cell_col = c;
      q.cell_row = r;
      q.entry_velocity = v;
      q.pos_x = $urandom;
      q.pos_y = $urandom;
      return q;
   endfunction

   function sgv_pkg::sgv_req_type make_sample(logic [31:0] px, logic [31:0] py);
      sgv_pkg::sgv_req_type q;
      q = make_write(sgv_pkg::OP_SAMPLE, 6'($urandom), 6'($urandom), $urandom);
      q.pos_x = px;
      q.pos_y = py;
      return q;
   endfunction

   function logic [31:0] random_pos(logic [15:0] dom);
      if (dom == 0 || $urandom_range(9) > 7) return $urandom;
      if ($urandom_range(9) == 0) return {dom, 16'h0} - $urandom_range(0, 3);
      return $urandom_range(0, {dom, 16'h0} - 1);
   endfunction

   function sgv_pkg::sgv_req_type random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         return make_write(sgv_pkg::OP_WRITE_H, 6'($urandom), 6'($urandom), $urandom);
      end
      if (pick < 50) begin
         return make_write(sgv_pkg::OP_WRITE_V, 6'($urandom), 6'($urandom), $urandom);
      end
      if (pick < 98) return make_sample(random_pos(sb.dom_w), random_pos(sb.dom_h));
      return make_write(sgv_pkg::OP_UNUSED, 6'($urandom), 6'($urandom), $urandom);
   endfunction

   function logic [31:0] init_vel(int k);
      case (k % 5)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // samples stay inside the loaded corner of both grids
      configure(16'(LOAD_SIDE), 16'(LOAD_SIDE), 16'd64, 16'd64);
      for (int k = 0; k < LOAD_SIDE * LOAD_SIDE; k++) begin
         send(make_write(sgv_pkg::OP_WRITE_H, 6'(k % LOAD_SIDE), 6'(k / LOAD_SIDE),
                         init_vel(k)));
      end
      for (int k = 0; k < LOAD_SIDE * LOAD_SIDE; k++) begin
         send(make_write(sgv_pkg::OP_WRITE_V, 6'(k % LOAD_SIDE), 6'(k / LOAD_SIDE),
                         init_vel(k + 2)));
      end

      send(make_sample(32'h0, 32'h0));
      send(make_sample(32'hffff_ffff, 32'hffff_ffff));
      send(make_sample(32'h003f_ffff, 32'h003f_ffff));
      send(make_sample(32'h0040_0000, 32'h0000_0000));
      send(make_sample(32'h0000_8000, 32'h0000_8000));
      send(make_sample(32'h0000_7fff, 32'h0000_7fff));
      send(make_sample(32'h0001_8000, 32'h0020_7fff));
      send(make_sample(32'h003f_8000, 32'h003f_7fff));
      send(make_write(sgv_pkg::OP_WRITE_H, 6'd63, 6'd63, 32'h7fff_ffff));
      send(make_write(sgv_pkg::OP_WRITE_V, 6'd0, 6'd0, 32'h8000_0000));
      send(make_write(sgv_pkg::OP_UNUSED, 6'd5, 6'd5, 32'h1234_5678));
      send(make_sample(32'h003f_c000, 32'h003f_c000));
      send(make_sample(32'h0000_4000, 32'h0000_4000));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: configure(16'd1, 16'd1, 16'd1, 16'd1);
            2: configure(16'd8, 16'd8, 16'hffff, 16'hffff);
            3: configure(16'd0, 16'd127, 16'd0, 16'd5);
            4: configure(16'd7, 16'd5, 16'd100, 16'd3);
            5: configure(16'($urandom_range(1, LOAD_SIDE)), 16'($urandom_range(1, LOAD_SIDE)),
                         16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
            default: ;
         endcase
         send_idle = (phase < 2) ? 28 : (phase < 4) ? 51 : 0;
         recv_idle = (phase < 2) ? 51 : (phase < 4) ? 28 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) send(random_request());
         drain();
      end

      if (sb.errors == 0 && sb.expected_vel.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/sgv_pkg.sv
sv/sgv_ram.sv
sv/staggered_grid_velocity_sample.sv
dv/tb.sv
